// File: hdl/thw_pkg.sv
package thw_pkg;

  localparam int SLOTS_DEF     = 8;
  localparam int TASK_ID_W_DEF = 8;

  localparam int TIME_W     = 32;
  localparam int CNT_W      = 16;
  localparam int OP_W       = 2;
  localparam int ST_W       = 2;
  localparam int SLOT_W     = 3;
  localparam int ID_IN_W    = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [TIME_W-1:0] TIMEOUT_RST  = 32'd3000;
  localparam logic [CNT_W-1:0]  INTERVAL_RST = 16'd500;

  // operation codes
  localparam logic [OP_W-1:0] OP_TICK = 2'd0;
  localparam logic [OP_W-1:0] OP_REG  = 2'd1;
  localparam logic [OP_W-1:0] OP_HB   = 2'd2;

  // result status codes
  localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
  localparam logic [ST_W-1:0] ST_UNKNOWN = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 1'b1;

  // command broadcast to every cell while a word walks the chain
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            scan;
  } cmd_t;

  // token handed from cell to cell
  typedef struct packed {
    logic valid;
    logic found;
  } tok_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_t;

endpackage

// File: hdl/thw_cell.sv
module thw_cell #(
  parameter int IDX   = 0,
  parameter int IDX_W = 3,
  parameter int ID_W  = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  thw_pkg::cmd_t             cmd,
  input  logic [ID_W-1:0]           id,
  input  logic [thw_pkg::TIME_W-1:0] now,
  input  logic [thw_pkg::TIME_W-1:0] timeout,
  input  thw_pkg::tok_t             tok_in,
  input  logic [IDX_W-1:0]          idx_in,
  output thw_pkg::tok_t             tok_out,
  output logic [IDX_W-1:0]          idx_out
);

  logic                       active_r;
  logic [ID_W-1:0]            task_r;
  logic [thw_pkg::TIME_W-1:0] stamp_r;
  thw_pkg::tok_t              tok_r;
  thw_pkg::tok_t              tok_nxt;
  logic [IDX_W-1:0]           idx_r;
  logic [thw_pkg::TIME_W-1:0] elapsed;
  logic                       hit;
  logic                       take;

  assign elapsed = now - stamp_r;

  always_comb begin
    case (cmd.op)
      thw_pkg::OP_TICK: hit = cmd.scan & active_r & (elapsed > timeout);
      thw_pkg::OP_REG:  hit = ~active_r;
      thw_pkg::OP_HB:   hit = active_r & (task_r == id);
      default:          hit = 1'b0;
    endcase
  end

  // first hit along the chain claims the word
  assign take          = tok_in.valid & ~tok_in.found & hit;
  assign tok_nxt.valid = tok_in.valid;
  assign tok_nxt.found = tok_in.found | take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      tok_r    <= '0;
    end else begin
      tok_r <= tok_nxt;
      if (take && cmd.op == thw_pkg::OP_REG) begin
        active_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= take ? IDX_W'(IDX) : idx_in;
    if (take && cmd.op == thw_pkg::OP_REG) begin
      task_r  <= id;
      stamp_r <= now;
    end else if (take && cmd.op == thw_pkg::OP_HB) begin
      stamp_r <= now;
    end
  end

  assign tok_out = tok_r;
  assign idx_out = idx_r;

endmodule

// File: hdl/task_heartbeat_watchdog_unit.sv
// Channel  Direction  Handshake               Payload
// in       input      in_valid / in_ready     in_op, in_task_id
// out      output     out_valid / out_ready   out_status, out_slot_used,
//                                             out_reset_request, out_timed_out_slot
// cfg      input      cfg_wr_en               cfg_index, cfg_wdata
//
// One word at a time: a word walks the cell chain one slot per cycle, and the
// next word is taken only after the previous result has left the chain and the
// block is back in its idle state; the chain length sets how long a walk lasts.
// Reset (rst_n low, synchronous) clears all active flags, time and interval count.
// A result stalled at the output holds the block in its done state; the next
// word is still taken once that result has moved into the output register.
module task_heartbeat_watchdog_unit #(
  parameter int SLOTS         = thw_pkg::SLOTS_DEF,
  parameter int TASK_ID_WIDTH = thw_pkg::TASK_ID_W_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [thw_pkg::OP_W-1:0]        in_op,
  input  logic [thw_pkg::ID_IN_W-1:0]     in_task_id,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [thw_pkg::ST_W-1:0]        out_status,
  output logic [thw_pkg::SLOT_W-1:0]      out_slot_used,
  output logic                            out_reset_request,
  output logic [thw_pkg::SLOT_W-1:0]      out_timed_out_slot,
  input  logic                            cfg_wr_en,
  input  logic [thw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [thw_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [thw_pkg::TIME_W-1:0] timeout_r;
  logic [thw_pkg::CNT_W-1:0]  interval_r;
  logic [thw_pkg::TIME_W-1:0] time_r, time_nxt;
  logic [thw_pkg::CNT_W-1:0]  cnt_r, cnt_nxt, cnt_inc;
  logic                       scan_nxt;
  thw_pkg::cmd_t              cmd_r;
  logic [TASK_ID_WIDTH-1:0]   id_r;
  logic                       launch_r;
  thw_pkg::state_t            state_r, state_nxt;

  logic                       accept;
  logic                       out_free;
  logic                       load_out;
  logic                       capture;

  logic [thw_pkg::ST_W-1:0]   res_status_r, res_status_nxt;
  logic [thw_pkg::SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic                       res_req_r, res_req_nxt;
  logic [thw_pkg::SLOT_W-1:0] res_tslot_r, res_tslot_nxt;

  logic                       out_valid_r;
  logic [thw_pkg::ST_W-1:0]   out_status_r;
  logic [thw_pkg::SLOT_W-1:0] out_slot_r;
  logic                       out_req_r;
  logic [thw_pkg::SLOT_W-1:0] out_tslot_r;

  thw_pkg::tok_t              tok [0:SLOTS];
  logic [IDX_W-1:0]           idx [0:SLOTS];

  assign accept   = in_valid & in_ready;
  assign out_free = ~out_valid_r | out_ready;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r  <= thw_pkg::TIMEOUT_RST;
      interval_r <= thw_pkg::INTERVAL_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        thw_pkg::CFG_TIMEOUT:  timeout_r  <= cfg_wdata;
        thw_pkg::CFG_INTERVAL: interval_r <= cfg_wdata[thw_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // time advances first, then the interval count; scan uses the new time
  always_comb begin
    time_nxt = time_r;
    cnt_nxt  = cnt_r;
    cnt_inc  = cnt_r + 1'b1;
    scan_nxt = 1'b0;
    if (in_op == thw_pkg::OP_TICK) begin
      time_nxt = time_r + 1'b1;
      if (cnt_inc >= interval_r) begin
        scan_nxt = 1'b1;
        cnt_nxt  = '0;
      end else begin
        cnt_nxt = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r   <= '0;
      cnt_r    <= '0;
      launch_r <= 1'b0;
    end else begin
      launch_r <= accept;
      if (accept) begin
        time_r <= time_nxt;
        cnt_r  <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r.op   <= in_op;
      cmd_r.scan <= scan_nxt;
      id_r       <= TASK_ID_WIDTH'(in_task_id);
    end
  end

  // cell chain
  assign tok[0].valid = launch_r;
  assign tok[0].found = 1'b0;
  assign idx[0]       = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    thw_cell #(
      .IDX   (g),
      .IDX_W (IDX_W),
      .ID_W  (TASK_ID_WIDTH)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd_r),
      .id      (id_r),
      .now     (time_r),
      .timeout (timeout_r),
      .tok_in  (tok[g]),
      .idx_in  (idx[g]),
      .tok_out (tok[g+1]),
      .idx_out (idx[g+1])
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      thw_pkg::S_IDLE: if (accept)         state_nxt = thw_pkg::S_WALK;
      thw_pkg::S_WALK: if (tok[SLOTS].valid) state_nxt = thw_pkg::S_DONE;
      thw_pkg::S_DONE: if (out_free)       state_nxt = thw_pkg::S_IDLE;
      default:                             state_nxt = thw_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= thw_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    capture  = 1'b0;
    load_out = 1'b0;
    case (state_r)
      thw_pkg::S_IDLE: in_ready = 1'b1;
      thw_pkg::S_WALK: capture  = tok[SLOTS].valid;
      thw_pkg::S_DONE: load_out = out_free;
      default: ;
    endcase
  end

  // result from the chain tail
  always_comb begin
    res_status_nxt = thw_pkg::ST_DONE;
    res_slot_nxt   = '0;
    res_req_nxt    = 1'b0;
    res_tslot_nxt  = '0;
    case (cmd_r.op)
      thw_pkg::OP_TICK: begin
        res_req_nxt   = tok[SLOTS].found;
        res_tslot_nxt = tok[SLOTS].found ? thw_pkg::SLOT_W'(idx[SLOTS]) : '0;
      end
      thw_pkg::OP_REG: begin
        res_status_nxt = tok[SLOTS].found ? thw_pkg::ST_DONE : thw_pkg::ST_FULL;
        res_slot_nxt   = tok[SLOTS].found ? thw_pkg::SLOT_W'(idx[SLOTS]) : '0;
      end
      thw_pkg::OP_HB: begin
        res_status_nxt = tok[SLOTS].found ? thw_pkg::ST_DONE : thw_pkg::ST_UNKNOWN;
        res_slot_nxt   = tok[SLOTS].found ? thw_pkg::SLOT_W'(idx[SLOTS]) : '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      res_status_r <= res_status_nxt;
      res_slot_r   <= res_slot_nxt;
      res_req_r    <= res_req_nxt;
      res_tslot_r  <= res_tslot_nxt;
    end
    if (load_out) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_req_r    <= res_req_r;
      out_tslot_r  <= res_tslot_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_slot_used      = out_slot_r;
  assign out_reset_request  = out_req_r;
  assign out_timed_out_slot = out_tslot_r;

endmodule

// File: hdl/thw_checker.sv
module thw_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [thw_pkg::ST_W-1:0]        out_status,
  input logic [thw_pkg::SLOT_W-1:0]      out_slot_used,
  input logic                            out_reset_request,
  input logic [thw_pkg::SLOT_W-1:0]      out_timed_out_slot
);

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // one word at a time: ready falls after every accept
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while the chain is busy");

  // a reset request only comes from a tick, which reports done and no slot
  a_req_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reset_request |->
      out_status == thw_pkg::ST_DONE && out_slot_used == '0)
    else $error("reset request on a register or heartbeat result");

  // failed register or heartbeat names no slot
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != thw_pkg::ST_DONE |->
      out_slot_used == '0 && !out_reset_request)
    else $error("failed word names a slot");

  a_tslot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_reset_request |-> out_timed_out_slot == '0)
    else $error("timed-out slot set without a reset request");

endmodule

bind task_heartbeat_watchdog_unit thw_checker u_thw_checker (.*);
